>>> design/ppgagc_pkg.sv
package ppgagc_pkg;

    // Width of one optical sample field
    localparam int SAMPLE_BITS = 18;
    // Width of the level registers (full scale, finger, coarse)
    localparam int LEVEL_BITS  = 18;
    localparam int AMP_BITS    = 8;
    localparam int PHASE_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;

    // 5*x and 3*fs compare width: wider of sample and level, plus three bits
    localparam int CMP_BITS =
        ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FULL_SCALE      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FINGER_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COARSE_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROUND_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_AMPLITUDE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_AMP_FLOOR       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_AMP_CEILING     = 3'd6;

    // Register reset values
    localparam logic [LEVEL_BITS-1:0] FULL_SCALE_RESET   = 18'd262143;
    localparam logic [LEVEL_BITS-1:0] FINGER_LEVEL_RESET = 18'd30000;
    localparam logic [LEVEL_BITS-1:0] COARSE_LEVEL_RESET = 18'd240000;
    localparam logic [AMP_BITS-1:0]   ROUND_LIMIT_RESET  = 8'd100;
    localparam logic [AMP_BITS-1:0]   START_AMP_RESET    = 8'h1F;
    localparam logic [AMP_BITS-1:0]   AMP_FLOOR_RESET    = 8'd10;
    localparam logic [AMP_BITS-1:0]   AMP_CEILING_RESET  = 8'd245;

    // Amplitude step sizes
    localparam logic [AMP_BITS-1:0] STEP_COARSE = 8'd5;
    localparam logic [AMP_BITS-1:0] STEP_FINE   = 8'd1;

    // Loop phase codes
    localparam logic [PHASE_BITS-1:0] PH_WAIT   = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_ADJUST = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_DONE   = 2'd2;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] full_scale;
        logic [LEVEL_BITS-1:0] finger_level;
        logic [LEVEL_BITS-1:0] coarse_level;
        logic [AMP_BITS-1:0]   round_limit;
        logic [AMP_BITS-1:0]   start_amplitude;
        logic [AMP_BITS-1:0]   amp_floor;
        logic [AMP_BITS-1:0]   amp_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red_sample;
        logic [SAMPLE_BITS-1:0] ir_sample;
        logic                   restart;
    } sample_t;

    typedef struct packed {
        logic [AMP_BITS-1:0]   red_amplitude;
        logic [AMP_BITS-1:0]   ir_amplitude;
        logic                  amplitude_changed;
        logic [PHASE_BITS-1:0] loop_phase;
        logic                  finger_seen;
    } result_t;

endpackage

>>> design/ppgagc_cfg.sv
module ppgagc_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ppgagc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ppgagc_pkg::LEVEL_BITS-1:0]    cfg_data,
    output ppgagc_pkg::cfg_t                     cfg
);

    ppgagc_pkg::cfg_t cfg_reg;
    ppgagc_pkg::cfg_t cfg_next;
    logic [ppgagc_pkg::AMP_BITS-1:0] data_amp;

    assign data_amp = cfg_data[ppgagc_pkg::AMP_BITS-1:0];

    // Decode the write; an index past the list is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ppgagc_pkg::REG_FULL_SCALE:      cfg_next.full_scale      = cfg_data;
                ppgagc_pkg::REG_FINGER_LEVEL:    cfg_next.finger_level    = cfg_data;
                ppgagc_pkg::REG_COARSE_LEVEL:    cfg_next.coarse_level    = cfg_data;
                ppgagc_pkg::REG_ROUND_LIMIT:     cfg_next.round_limit     = data_amp;
                ppgagc_pkg::REG_START_AMPLITUDE: cfg_next.start_amplitude = data_amp;
                ppgagc_pkg::REG_AMP_FLOOR:       cfg_next.amp_floor       = data_amp;
                ppgagc_pkg::REG_AMP_CEILING:     cfg_next.amp_ceiling     = data_amp;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale      <= ppgagc_pkg::FULL_SCALE_RESET;
            cfg_reg.finger_level    <= ppgagc_pkg::FINGER_LEVEL_RESET;
            cfg_reg.coarse_level    <= ppgagc_pkg::COARSE_LEVEL_RESET;
            cfg_reg.round_limit     <= ppgagc_pkg::ROUND_LIMIT_RESET;
            cfg_reg.start_amplitude <= ppgagc_pkg::START_AMP_RESET;
            cfg_reg.amp_floor       <= ppgagc_pkg::AMP_FLOOR_RESET;
            cfg_reg.amp_ceiling     <= ppgagc_pkg::AMP_CEILING_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/ppgagc_chan.sv
module ppgagc_chan
(
    input  logic [ppgagc_pkg::SAMPLE_BITS-1:0] x,
    input  logic [ppgagc_pkg::AMP_BITS-1:0]    amp,
    input  ppgagc_pkg::cfg_t                   cfg,
    output logic [ppgagc_pkg::AMP_BITS-1:0]    amp_next,
    output logic                               changed
);

    localparam int CB = ppgagc_pkg::CMP_BITS;

    logic [CB-1:0] x5;
    logic [CB-1:0] fs3;
    logic [CB-1:0] fs2;
    logic          is_high;
    logic          is_low;
    logic          step_down;
    logic          step_up;
    logic [ppgagc_pkg::AMP_BITS-1:0] step;

    // Exact forms of x > 0.6*fs and x < 0.4*fs
    assign x5  = CB'({x, 2'b00}) + CB'(x);
    assign fs2 = CB'({cfg.full_scale, 1'b0});
    assign fs3 = fs2 + CB'(cfg.full_scale);

    assign is_high   = x5 > fs3;
    assign is_low    = x5 < fs2;
    assign step_down = is_high && (amp > cfg.amp_floor);
    assign step_up   = !step_down && is_low && (amp < cfg.amp_ceiling);

    assign step = (CB'(x) > CB'(cfg.coarse_level)) ?
                  ppgagc_pkg::STEP_COARSE : ppgagc_pkg::STEP_FINE;

    always_comb
    begin
        amp_next = amp;
        if (step_down)
        begin
            // Saturate at zero
            amp_next = (amp > step) ? (amp - step) : '0;
        end
        else if (step_up)
        begin
            amp_next = amp + ppgagc_pkg::STEP_FINE;
        end
    end

    assign changed = step_down || step_up;

endmodule

>>> design/ppg_led_current_agc.sv
// LED drive gain control for a red/infrared optical front end. Each sample
// beat carries one red/IR count pair and returns exactly one result beat with
// both LED amplitudes, a changed flag, the loop phase and finger detection.
// The loop waits for a finger (either channel at or above finger_level); the
// detecting beat only moves it to adjusting. While adjusting, a beat with a
// finger present steps each channel down (by 5 above coarse_level, else by 1)
// when 5*x > 3*full_scale and the amplitude is above amp_floor, or up by 1
// when 5*x < 2*full_scale and the amplitude is below amp_ceiling, and counts
// one round; after round_limit rounds the loop is done and holds. A beat with
// restart set reloads start_amplitude and returns to waiting. Throughput is
// one beat per clock while result_ready is high; an accepted beat is loaded
// into the input register, and the single-pass regulation then writes the
// result register, which raises result valid.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while no beat is in flight (not enforced).
module ppg_led_current_agc
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ppgagc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ppgagc_pkg::LEVEL_BITS-1:0]    cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  ppgagc_pkg::sample_t                  sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ppgagc_pkg::result_t                  result
);

    localparam int CB = ppgagc_pkg::CMP_BITS;

    ppgagc_pkg::cfg_t cfg;

    // Input stage
    ppgagc_pkg::sample_t in_reg;
    logic                in_valid_reg;

    // Loop state
    logic [ppgagc_pkg::PHASE_BITS-1:0] phase_reg;
    logic [ppgagc_pkg::PHASE_BITS-1:0] phase_next;
    logic [ppgagc_pkg::AMP_BITS-1:0]   red_drive_reg;
    logic [ppgagc_pkg::AMP_BITS-1:0]   red_drive_next;
    logic [ppgagc_pkg::AMP_BITS-1:0]   ir_drive_reg;
    logic [ppgagc_pkg::AMP_BITS-1:0]   ir_drive_next;
    logic [ppgagc_pkg::AMP_BITS-1:0]   round_count_reg;
    logic [ppgagc_pkg::AMP_BITS-1:0]   round_count_next;

    // Result stage
    ppgagc_pkg::result_t out_reg;
    ppgagc_pkg::result_t out_next;
    logic                out_valid_reg;

    logic                              advance;
    logic                              finger;
    logic [ppgagc_pkg::AMP_BITS-1:0]   red_amp_out;
    logic [ppgagc_pkg::AMP_BITS-1:0]   ir_amp_out;
    logic                              red_changed;
    logic                              ir_changed;
    logic [ppgagc_pkg::AMP_BITS-1:0]   round_inc;

    ppgagc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppgagc_chan u_red
    (
        .x        (in_reg.red_sample),
        .amp      (red_drive_reg),
        .cfg      (cfg),
        .amp_next (red_amp_out),
        .changed  (red_changed)
    );

    ppgagc_chan u_ir
    (
        .x        (in_reg.ir_sample),
        .amp      (ir_drive_reg),
        .cfg      (cfg),
        .amp_next (ir_amp_out),
        .changed  (ir_changed)
    );

    // Move the held beat on whenever the result register is free or drained
    assign advance      = !out_valid_reg || result_ready;
    assign sample_ready = !in_valid_reg || advance;

    assign finger = (CB'(in_reg.red_sample) >= CB'(cfg.finger_level)) ||
                    (CB'(in_reg.ir_sample)  >= CB'(cfg.finger_level));

    assign round_inc = round_count_reg + ppgagc_pkg::AMP_BITS'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        red_drive_next   = red_drive_reg;
        ir_drive_next    = ir_drive_reg;
        round_count_next = round_count_reg;
        out_next.amplitude_changed = 1'b0;
        out_next.finger_seen       = 1'b0;

        if (in_reg.restart)
        begin
            // Drop the sample, reload the start amplitudes
            red_drive_next   = cfg.start_amplitude;
            ir_drive_next    = cfg.start_amplitude;
            phase_next       = ppgagc_pkg::PH_WAIT;
            round_count_next = '0;
        end
        else
        begin
            out_next.finger_seen = finger;
            case (phase_reg)
                ppgagc_pkg::PH_WAIT:
                begin
                    if (finger)
                    begin
                        phase_next = ppgagc_pkg::PH_ADJUST;
                    end
                end
                ppgagc_pkg::PH_ADJUST:
                begin
                    // No finger: pause, leave everything as it is
                    if (finger)
                    begin
                        red_drive_next   = red_amp_out;
                        ir_drive_next    = ir_amp_out;
                        out_next.amplitude_changed = red_changed || ir_changed;
                        round_count_next = round_inc;
                        if (round_inc >= cfg.round_limit)
                        begin
                            phase_next = ppgagc_pkg::PH_DONE;
                        end
                    end
                end
                default:
                begin
                    // Done: hold amplitudes and phase
                    phase_next = phase_reg;
                end
            endcase
        end

        out_next.red_amplitude = red_drive_next;
        out_next.ir_amplitude  = ir_drive_next;
        out_next.loop_phase    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= ppgagc_pkg::PH_WAIT;
            red_drive_reg   <= ppgagc_pkg::START_AMP_RESET;
            ir_drive_reg    <= ppgagc_pkg::START_AMP_RESET;
            round_count_reg <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    phase_reg       <= phase_next;
                    red_drive_reg   <= red_drive_next;
                    ir_drive_reg    <= ir_drive_next;
                    round_count_reg <= round_count_next;
                end
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_reg <= sample;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A held beat is never lost while the result side stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input beat dropped during stall");

    // A shown result always mirrors the loop state it left behind
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.red_amplitude == red_drive_reg) &&
                          (out_reg.ir_amplitude == ir_drive_reg) &&
                          (out_reg.loop_phase == phase_reg))
        else $error("result does not match loop state");

    // An amplitude change needs a finger and the loop out of waiting
    a_change_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.amplitude_changed) |->
            (out_reg.finger_seen &&
             ((out_reg.loop_phase == ppgagc_pkg::PH_ADJUST) ||
              (out_reg.loop_phase == ppgagc_pkg::PH_DONE))))
        else $error("amplitude changed without cause");

    // Once done, only a restart beat may move the drives or the phase
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == ppgagc_pkg::PH_DONE) &&
         !(advance && in_valid_reg && in_reg.restart)) |=>
            ($stable(red_drive_reg) && $stable(ir_drive_reg) &&
             (phase_reg == ppgagc_pkg::PH_DONE)))
        else $error("done phase not held");

endmodule
